@@ src/csv_stream_tokenizer_defines.svh @@
// Assertion macros used by the tokenizer top level.
// Expects clk and rst in the scope of each use.
`ifndef CSV_STREAM_TOKENIZER_DEFINES_SVH
`define CSV_STREAM_TOKENIZER_DEFINES_SVH

// Condition must hold in the same cycle
`define CSVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csvt: assertion failed");

// Condition must hold in the following cycle
`define CSVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csvt: assertion failed");

`endif

@@ src/csvt_pkg.sv @@
// Shared types and constants for the CSV stream tokenizer.
// No dependencies.
package csvt_pkg;

  localparam int CHAR_WIDTH = 16;

  typedef logic [CHAR_WIDTH-1:0] char_t;

  localparam char_t CODE_CR = char_t'(13);
  localparam char_t CODE_LF = char_t'(10);

  localparam char_t DELIM_RST   = char_t'(44);
  localparam char_t QUOTE_RST   = char_t'(34);
  localparam char_t COMMENT_RST = char_t'(35);

  typedef enum logic [1:0] {
    TOK_DATA      = 2'd0,
    TOK_FIELD     = 2'd1,
    TOK_FIELD_REC = 2'd2,
    TOK_REC       = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    CFG_DELIM   = 2'd0,
    CFG_QUOTE   = 2'd1,
    CFG_COMMENT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    char_t delim;
    char_t quote;
    char_t comment;
  } cfg_t;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic in_comment;
    logic at_line_start;
    logic field_has_chars;
    logic record_has_fields;
  } flags_t;

  localparam flags_t FLAGS_RST = '{
    in_quotes: 1'b0, quote_pending: 1'b0, in_comment: 1'b0,
    at_line_start: 1'b1, field_has_chars: 1'b0, record_has_fields: 1'b0
  };

  typedef struct packed {
    tok_kind_t kind;
    char_t     ch;
  } token_t;

endpackage

@@ src/csvt_if.sv @@
// Valid/ready channel interfaces for character input and token output.
// Depends on csvt_pkg.
interface csvt_in_if;
  logic                valid;
  logic                ready;
  csvt_pkg::char_t     char_code;
  logic                end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          token_kind;
  csvt_pkg::char_t     out_char;

  modport source (output valid, output token_kind, output out_char, input ready);
  modport sink (input valid, input token_kind, input out_char, output ready);
endinterface

@@ src/csvt_cfg_regs.sv @@
// Delimiter, quote and comment character registers with plain write port.
// Depends on csvt_pkg.
module csvt_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  csvt_pkg::char_t cfg_data,
  output csvt_pkg::cfg_t cfg
);
  import csvt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim   <= DELIM_RST;
      cfg.quote   <= QUOTE_RST;
      cfg.comment <= COMMENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIM:   cfg.delim   <= cfg_data;
        CFG_QUOTE:   cfg.quote   <= cfg_data;
        CFG_COMMENT: cfg.comment <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/csvt_core.sv @@
// Input register, parser flags and the per-character step logic.
// Depends on csvt_pkg and csvt_in_if.
module csvt_core (
  input  logic            clk,
  input  logic            rst,
  input  csvt_pkg::cfg_t  cfg,
  csvt_in_if.sink         in_ch,
  output logic            tok_valid,
  input  logic            tok_ready,
  output csvt_pkg::token_t tok,
  output csvt_pkg::flags_t flags
);
  import csvt_pkg::*;

  logic   held;
  char_t  c;
  logic   eoi;
  logic   advance;
  logic   emit;
  logic   done;
  flags_t flags_next;

  always_comb begin
    flags_next = flags;
    emit       = 1'b0;
    done       = 1'b0;
    tok.kind   = TOK_DATA;
    tok.ch     = '0;
    if (eoi) begin
      if (flags.field_has_chars) begin
        emit     = 1'b1;
        tok.kind = TOK_FIELD_REC;
      end else if (flags.record_has_fields) begin
        emit     = 1'b1;
        tok.kind = TOK_REC;
      end
      flags_next = FLAGS_RST;
    end else begin
      if (flags.quote_pending) begin
        flags_next.quote_pending = 1'b0;
        if (c == cfg.quote) begin
          flags_next.field_has_chars = 1'b1;
          flags_next.at_line_start   = 1'b0;
          emit   = 1'b1;
          tok.ch = cfg.quote;
          done   = 1'b1;
        end else if (c == CODE_CR || c == CODE_LF || c == cfg.delim) begin
          flags_next.in_quotes = 1'b0;
        end
      end
      if (!done) begin
        if (c == CODE_CR) begin
          // dropped
        end else if (c == CODE_LF && !flags_next.in_quotes) begin
          emit     = !flags_next.in_comment;
          tok.kind = TOK_FIELD_REC;
          flags_next.in_comment        = 1'b0;
          flags_next.at_line_start     = 1'b1;
          flags_next.field_has_chars   = 1'b0;
          flags_next.record_has_fields = 1'b0;
        end else if (c == cfg.comment && !flags_next.in_quotes &&
                     flags_next.at_line_start) begin
          flags_next.in_comment    = 1'b1;
          flags_next.at_line_start = 1'b0;
        end else begin
          flags_next.at_line_start = 1'b0;
          if (flags_next.in_comment) begin
            // comment line swallows everything
          end else if (!flags_next.field_has_chars && c == cfg.quote &&
                       !flags_next.in_quotes) begin
            flags_next.in_quotes = 1'b1;
          end else if (c == cfg.delim && !flags_next.in_quotes) begin
            flags_next.field_has_chars   = 1'b0;
            flags_next.record_has_fields = 1'b1;
            emit     = 1'b1;
            tok.kind = TOK_FIELD;
          end else if (c == cfg.quote && flags_next.in_quotes) begin
            flags_next.quote_pending = 1'b1;
          end else begin
            flags_next.field_has_chars = 1'b1;
            emit   = 1'b1;
            tok.ch = c;
          end
        end
      end
    end
  end

  assign tok_valid   = held && emit;
  assign advance     = held && (!emit || tok_ready);
  assign in_ch.ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      flags <= FLAGS_RST;
    end else begin
      if (advance) begin
        flags <= flags_next;
      end
      if (in_ch.ready) begin
        held <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      c   <= in_ch.char_code;
      eoi <= in_ch.end_of_input;
    end
  end

endmodule

@@ src/csvt_out_reg.sv @@
// Output token register between the step logic and the output channel.
// Depends on csvt_pkg and csvt_out_if.
module csvt_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  csvt_pkg::token_t tok,
  csvt_out_if.source       out_ch
);
  import csvt_pkg::*;

  assign tok_ready = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (tok_ready) begin
      out_ch.valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid && tok_ready) begin
      out_ch.token_kind <= tok.kind;
      out_ch.out_char   <= tok.ch;
    end
  end

endmodule

@@ src/csv_stream_tokenizer.sv @@
// CSV stream tokenizer top level: one character item in, at most one token out.
// Token path: an accepted item is held in the input register, and its token is captured in the token register.
// Throughput: 1 item per cycle; input stalls only while a token waits in a full output.
// Reset (rst, synchronous): parser flags to line start, registers to ',' '"' '#'.
// Depends on csvt_pkg, csvt_if, csvt_cfg_regs, csvt_core, csvt_out_reg.
`include "csv_stream_tokenizer_defines.svh"
module csv_stream_tokenizer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  csvt_pkg::char_t cfg_data,
  csvt_in_if.sink         in_ch,
  csvt_out_if.source      out_ch
);
  import csvt_pkg::*;

  cfg_t   cfg;
  token_t tok;
  logic   tok_valid;
  logic   tok_ready;
  flags_t flags;

  csvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csvt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .flags     (flags)
  );

  csvt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .out_ch    (out_ch)
  );

  `CSVT_ASSERT_NOW(a_stall_needs_full_out, !in_ch.ready, out_ch.valid)
  `CSVT_ASSERT_NOW(a_ctrl_tok_no_char, out_ch.valid && out_ch.token_kind != TOK_DATA,
                   out_ch.out_char == '0)
  `CSVT_ASSERT_NOW(a_pending_in_quotes, flags.quote_pending, flags.in_quotes)
  `CSVT_ASSERT_NOW(a_comment_not_quoted, flags.in_comment, !flags.in_quotes)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for csv_stream_tokenizer: directed and random character
// streams against a cycle-free token predictor, with random bursts and output stalls.
// Depends on csvt_pkg, csvt_if and the tokenizer RTL.
`timescale 1ns / 100ps
module tb;
  import csvt_pkg::*;

  typedef struct packed {
    logic  eoi;
    char_t code;
  } char_item_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_we;
  logic  [1:0] cfg_index;
  char_t cfg_data;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_stream_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  char_item_t chars_pending[$];
  token_t     tokens_due[$];
  cfg_t       pcfg = '{delim: DELIM_RST, quote: QUOTE_RST, comment: COMMENT_RST};
  flags_t     pflags = FLAGS_RST;
  int         mismatches = 0;
  int         pushed = 0;
  bit         in_taken = 1'b0;

  // Token predictor: one input item in, at most one token out.
  function automatic bit parse_char(input bit eoi, input char_t c, output token_t tok);
    bit was_comment;
    tok = '{kind: TOK_DATA, ch: '0};
    if (eoi) begin
      was_comment = 1'b0;
      if (pflags.field_has_chars) begin
        tok.kind = TOK_FIELD_REC;
        was_comment = 1'b1;
      end else if (pflags.record_has_fields) begin
        tok.kind = TOK_REC;
        was_comment = 1'b1;
      end
      pflags = FLAGS_RST;
      return was_comment;
    end
    if (pflags.quote_pending) begin
      pflags.quote_pending = 1'b0;
      if (c == pcfg.quote) begin
        pflags.field_has_chars = 1'b1;
        pflags.at_line_start = 1'b0;
        tok.ch = c;
        return 1'b1;
      end
      if (c == CODE_CR || c == CODE_LF || c == pcfg.delim) pflags.in_quotes = 1'b0;
    end
    if (c == CODE_CR) return 1'b0;
    if (c == CODE_LF && !pflags.in_quotes) begin
      was_comment = pflags.in_comment;
      pflags.in_comment = 1'b0;
      pflags.at_line_start = 1'b1;
      pflags.field_has_chars = 1'b0;
      pflags.record_has_fields = 1'b0;
      tok.kind = TOK_FIELD_REC;
      return !was_comment;
    end
    if (c == pcfg.comment && !pflags.in_quotes && pflags.at_line_start) begin
      pflags.in_comment = 1'b1;
      pflags.at_line_start = 1'b0;
      return 1'b0;
    end
    pflags.at_line_start = 1'b0;
    if (pflags.in_comment) return 1'b0;
    if (!pflags.field_has_chars && c == pcfg.quote && !pflags.in_quotes) begin
      pflags.in_quotes = 1'b1;
      return 1'b0;
    end
    if (c == pcfg.delim && !pflags.in_quotes) begin
      pflags.field_has_chars = 1'b0;
      pflags.record_has_fields = 1'b1;
      tok.kind = TOK_FIELD;
      return 1'b1;
    end
    if (c == pcfg.quote && pflags.in_quotes) begin
      pflags.quote_pending = 1'b1;
      return 1'b0;
    end
    pflags.field_has_chars = 1'b1;
    tok.ch = c;
    return 1'b1;
  endfunction

  // Accepted items feed the predictor; accepted tokens are checked in order.
  always @(posedge clk) begin
    token_t     tok;
    token_t     want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        void'(chars_pending.pop_front());
        if (parse_char(in_ch.end_of_input, in_ch.char_code, tok))
          tokens_due.insert(tokens_due.size(), tok);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tokens_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token: kind %0d char %h", out_ch.token_kind, out_ch.out_char);
        end else begin
          want = tokens_due.pop_front();
          if (out_ch.token_kind !== want.kind || out_ch.out_char !== want.ch) begin
            mismatches++;
            if (mismatches <= 10)
              $display("token mismatch: expected kind %0d char %h, got kind %0d char %h",
                       want.kind, want.ch, out_ch.token_kind, out_ch.out_char);
          end
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps.
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (chars_pending.size() != 0) begin
      in_ch.valid <= 1'b1;
      in_ch.char_code <= chars_pending[0].code;
      in_ch.end_of_input <= chars_pending[0].eoi;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: ready follows a short repeating pattern, renewed now and then.
  logic [15:0] ready_pat = 16'hFFFF;
  int pat_len = 1;
  int pat_pos = 0;
  int pat_age = 0;

  always @(negedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(20, 120);
      ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      pat_len = $urandom_range(2, 16);
      pat_pos = 0;
    end
    pat_age--;
    out_ch.ready <= ready_pat[pat_pos];
    pat_pos = (pat_pos + 1) % pat_len;
  end

  task automatic push_code(input char_t c);
    chars_pending.insert(chars_pending.size(), char_item_t'{eoi: 1'b0, code: c});
    pushed++;
  endtask

  task automatic push_end();
    chars_pending.insert(chars_pending.size(),
                         char_item_t'{eoi: 1'b1, code: char_t'($urandom_range(0, 65535))});
    pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_code(char_t'(s[i]));
  endtask

  function automatic char_t any_char();
    case ($urandom_range(0, 9))
      0: return pcfg.delim;
      1: return pcfg.quote;
      2: return pcfg.comment;
      3: return CODE_CR;
      4: return CODE_LF;
      5, 9: return char_t'($urandom_range(32, 126));
      6, 7: return char_t'($urandom_range(0, 65535));
      default: return $urandom_range(0, 1) ? char_t'(16'hFFFF) : char_t'(0);
    endcase
  endfunction

  function automatic char_t plain_char();
    char_t c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? char_t'($urandom_range(0, 65535))
                                       : char_t'($urandom_range(32, 126));
    end while (c == pcfg.delim || c == pcfg.quote || c == CODE_CR || c == CODE_LF);
    return c;
  endfunction

  task automatic gen_record();
    int nf;
    int len;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) push_code(pcfg.delim);
      case ($urandom_range(0, 3))
        0: begin
        end
        1, 2: begin
          len = $urandom_range(1, 6);
          repeat (len) push_code(plain_char());
        end
        default: begin
          push_code(pcfg.quote);
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: begin
                push_code(pcfg.quote);
                push_code(pcfg.quote);
              end
              1: push_code(pcfg.delim);
              2: push_code(CODE_LF);
              3: push_code(CODE_CR);
              default: push_code(plain_char());
            endcase
          end
          push_code(pcfg.quote);
          if ($urandom_range(0, 7) == 0) push_code(plain_char());
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0: begin
        push_code(CODE_CR);
        push_code(CODE_LF);
      end
      1: push_end();
      default: push_code(CODE_LF);
    endcase
  endtask

  task automatic gen_phase(input int count);
    int start;
    start = pushed;
    while (pushed - start < count) begin
      case ($urandom_range(0, 9))
        0: begin
          push_code(pcfg.comment);
          repeat ($urandom_range(0, 5)) push_code(any_char());
          push_code(CODE_LF);
        end
        1: begin
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 15) == 0) push_end();
            else push_code(any_char());
          end
        end
        default: gen_record();
      endcase
    end
  endtask

  task automatic wait_idle();
    while (chars_pending.size() != 0 || tokens_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles; call at a falling edge.
  task automatic set_regs(input char_t d, input char_t q, input char_t c);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELIM;
    cfg_data <= d;
    pcfg.delim = d;
    @(negedge clk);
    cfg_index <= CFG_QUOTE;
    cfg_data <= q;
    pcfg.quote = q;
    @(negedge clk);
    cfg_index <= CFG_COMMENT;
    cfg_data <= c;
    pcfg.comment = c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_DELIM;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // comment line, code extremes, quoted field cases, stray quote, flush variants
    push_text("#x\n");
    push_code(char_t'(0));
    push_code(char_t'(16'hFFFF));
    push_text(",\"a\n\"\"\"x\"");
    push_code(CODE_CR);
    push_text(",b\"\n\nc");
    push_end();
    push_text(",");
    push_end();
    push_end();
    push_text("\"\"");
    push_end();
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
        end
        1: set_regs(char_t'(59), char_t'(39), char_t'(37));
        2: set_regs(char_t'(0), char_t'(16'hFFFF), char_t'(0));
        3: set_regs(char_t'(16'hFFFF), char_t'(0), char_t'(16'hFFFF));
        4: set_regs(DELIM_RST, DELIM_RST, DELIM_RST);
        5: set_regs(CODE_LF, CODE_CR, QUOTE_RST);
        6: set_regs(char_t'($urandom_range(0, 65535)), char_t'($urandom_range(0, 65535)),
                    char_t'($urandom_range(0, 65535)));
        default: set_regs(DELIM_RST, QUOTE_RST, COMMENT_RST);
      endcase
      gen_phase(200);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
